[hdl/integer_divide_remainder_unit_macros.svh]
// ----------------------------------------------------------------------------
// Integer divide / remainder unit: assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_DIVIDE_REMAINDER_UNIT_MACROS_SVH
`define INTEGER_DIVIDE_REMAINDER_UNIT_MACROS_SVH

// same-cycle implication
`define IDRU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IDRU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/idru_pkg.sv]
// ----------------------------------------------------------------------------
// idru_pkg
// Types, codes and helpers shared by the divide / remainder unit.
// ----------------------------------------------------------------------------
package idru_pkg;

	localparam int XLEN       = 64;
	localparam int WLEN       = 32;
	localparam int FIFO_DEPTH = 4;

	// operation codes
	localparam logic [1:0] CMD_DIV  = 2'd0;
	localparam logic [1:0] CMD_DIVU = 2'd1;
	localparam logic [1:0] CMD_REM  = 2'd2;
	localparam logic [1:0] CMD_REMU = 2'd3;

	// result fixup controls
	typedef struct packed {
		logic want_rem;
		logic word;
		logic neg_q;
		logic neg_r;
	} idru_ctl_t;

	// one queued operation: magnitudes plus fixup controls
	typedef struct packed {
		logic [XLEN-1:0] ma;
		logic [XLEN-1:0] mb;
		idru_ctl_t       ctl;
	} idru_op_t;

	typedef struct packed {
		logic [XLEN-1:0] rem;
		logic [XLEN-1:0] quo;
	} idru_part_t;

	// one restoring division step: shift in next dividend bit, trial subtract
	function automatic idru_part_t div_step(idru_part_t p, logic [XLEN-1:0] d);
		logic [XLEN:0]   sh;
		logic [XLEN+1:0] diff;
		logic            ge;
		idru_part_t      n;
		sh   = {p.rem, p.quo[XLEN-1]};
		diff = {1'b0, sh} - {2'b00, d};
		ge   = ~diff[XLEN+1];
		n.rem = ge ? diff[XLEN-1:0] : sh[XLEN-1:0];
		n.quo = {p.quo[XLEN-2:0], ge};
		return n;
	endfunction

	function automatic logic [XLEN-1:0] sext_word(logic [XLEN-1:0] v);
		return {{(XLEN-WLEN){v[WLEN-1]}}, v[WLEN-1:0]};
	endfunction

endpackage

[hdl/idru_front.sv]
// ----------------------------------------------------------------------------
// idru_front
// Decodes the operation, narrows word operands and forms the magnitudes.
// ----------------------------------------------------------------------------
module idru_front (
	input  logic [1:0]               cmd,
	input  logic                     word_op,
	input  logic [idru_pkg::XLEN-1:0] dividend,
	input  logic [idru_pkg::XLEN-1:0] divisor,
	output idru_pkg::idru_op_t       op
);
	import idru_pkg::*;

	logic            is_signed;
	logic [XLEN-1:0] a, b;
	logic            neg_a, neg_b, dz;

	// operand extension for word forms
	always_comb begin
		is_signed = (cmd == CMD_DIV) || (cmd == CMD_REM);
		a = dividend;
		b = divisor;
		if (word_op) begin
			if (is_signed) begin
				a = sext_word(dividend);
				b = sext_word(divisor);
			end else begin
				a = {{(XLEN-WLEN){1'b0}}, dividend[WLEN-1:0]};
				b = {{(XLEN-WLEN){1'b0}}, divisor[WLEN-1:0]};
			end
		end
	end

	// magnitudes and sign fixups; zero divisor keeps an all-ones quotient
	always_comb begin
		neg_a = is_signed & a[XLEN-1];
		neg_b = is_signed & b[XLEN-1];
		dz    = (b == '0);
		op.ma = neg_a ? (XLEN'(0) - a) : a;
		op.mb = neg_b ? (XLEN'(0) - b) : b;
		op.ctl.want_rem = (cmd == CMD_REM) || (cmd == CMD_REMU);
		op.ctl.word     = word_op;
		op.ctl.neg_q    = (neg_a ^ neg_b) & ~dz;
		op.ctl.neg_r    = neg_a;
	end

endmodule

[hdl/idru_queue.sv]
// ----------------------------------------------------------------------------
// idru_queue
// Short queue between the front and the divide pipeline.
// ----------------------------------------------------------------------------
module idru_queue #(
	parameter int DEPTH = idru_pkg::FIFO_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_valid,
	output logic                       wr_ready,
	input  idru_pkg::idru_op_t         wr_data,
	output logic                       rd_valid,
	input  logic                       rd_ready,
	output idru_pkg::idru_op_t         rd_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	import idru_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	idru_op_t        mem [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push, pop;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid & wr_ready;
	assign pop      = rd_valid & rd_ready;
	assign rd_data  = mem[rd_ptr_q];
	assign count    = count_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/idru_back.sv]
// ----------------------------------------------------------------------------
// idru_back
// Pipelined restoring divider, one quotient bit per stage, then sign and
// word fixup into the output register.
// ----------------------------------------------------------------------------
module idru_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  idru_pkg::idru_op_t        in_op,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [idru_pkg::XLEN-1:0] out_result
);
	import idru_pkg::*;

	localparam int NSTEP = XLEN;

	logic            adv;
	logic            vld_s  [NSTEP];
	logic [XLEN-1:0] rem_s  [NSTEP];
	logic [XLEN-1:0] quo_s  [NSTEP];
	logic [XLEN-1:0] dvs_s  [NSTEP];
	idru_ctl_t       ctl_s  [NSTEP];
	logic            out_valid_q;
	logic [XLEN-1:0] out_result_q;
	logic [XLEN-1:0] res_raw, res_fix;
	idru_ctl_t       lc;

	// whole pipeline moves unless the output beat is stalled
	assign adv       = ~out_valid_q | out_ready;
	assign in_ready  = adv;
	assign out_valid = out_valid_q;
	assign out_result = out_result_q;

	// first step from the queue head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		idru_part_t p;
		p = div_step('{rem: '0, quo: in_op.ma}, in_op.mb);
		if (adv) begin
			rem_s[0] <= p.rem;
			quo_s[0] <= p.quo;
			dvs_s[0] <= in_op.mb;
			ctl_s[0] <= in_op.ctl;
		end
	end

	// remaining steps
	for (genvar k = 1; k < NSTEP; k++) begin : g_step
		idru_part_t nxt;
		assign nxt = div_step('{rem: rem_s[k-1], quo: quo_s[k-1]}, dvs_s[k-1]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k] <= nxt.rem;
				quo_s[k] <= nxt.quo;
				dvs_s[k] <= dvs_s[k-1];
				ctl_s[k] <= ctl_s[k-1];
			end
		end
	end

	// sign and word fixup
	always_comb begin
		lc = ctl_s[NSTEP-1];
		if (lc.want_rem) begin
			res_raw = lc.neg_r ? (XLEN'(0) - rem_s[NSTEP-1]) : rem_s[NSTEP-1];
		end else begin
			res_raw = lc.neg_q ? (XLEN'(0) - quo_s[NSTEP-1]) : quo_s[NSTEP-1];
		end
		res_fix = lc.word ? sext_word(res_raw) : res_raw;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s[NSTEP-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_result_q <= res_fix;
		end
	end

endmodule

[hdl/integer_divide_remainder_unit.sv]
// ----------------------------------------------------------------------------
// integer_divide_remainder_unit
// 64-bit divide / remainder with word forms, fully pipelined.
//
//  channel   dir  payload
//  s_axis    in   tuser: cmd, word_op   tdata: dividend, divisor
//  m_axis    out  tdata: result
//
// One beat accepted per cycle while the queue has room; one result per cycle while the output is not stalled.
// An accepted operation is written into the queue; the queue head then moves
// into the first of 64 restoring stages (one per quotient bit), through the
// remaining stages, then the fixup / output register.
// A stalled output beat freezes the whole pipeline; the queue keeps taking
// beats until it holds FIFO_DEPTH operations.
// Reset clears only valid bits, queue pointers and the fill count; no clearing pass.
// ----------------------------------------------------------------------------
`include "integer_divide_remainder_unit_macros.svh"

module integer_divide_remainder_unit #(
	parameter int FIFO_DEPTH = idru_pkg::FIFO_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // dividend[63:0], divisor[127:64]
	input  logic [2:0]   s_axis_tuser,   // cmd[1:0], word_op[2]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata    // result[63:0]
);
	import idru_pkg::*;

	localparam int CW = $clog2(FIFO_DEPTH+1);

	idru_op_t      fr_op, q_op;
	logic          q_valid, q_ready;
	logic [CW-1:0] q_count;
	logic          out_stall;

	idru_front u_front (
		.cmd      (s_axis_tuser[1:0]),
		.word_op  (s_axis_tuser[2]),
		.dividend (s_axis_tdata[63:0]),
		.divisor  (s_axis_tdata[127:64]),
		.op       (fr_op)
	);

	idru_queue #(.DEPTH(FIFO_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (s_axis_tvalid),
		.wr_ready (s_axis_tready),
		.wr_data  (fr_op),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_op),
		.count    (q_count)
	);

	idru_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (q_valid),
		.in_ready   (q_ready),
		.in_op      (q_op),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (m_axis_tdata)
	);

	assign out_stall = m_axis_tvalid && !m_axis_tready;

	// queue never overfills
	`IDRU_ASSERT_NOW(a_q_bound, 1'b1, q_count <= CW'(FIFO_DEPTH), "queue overfilled")
	// a stalled result blocks draining of the queue
	`IDRU_ASSERT_NEXT(a_stall_hold, out_stall, q_count >= $past(q_count), "queue drained in stall")
	// input stalls only when the queue is full
	`IDRU_ASSERT_NOW(a_in_ready, !s_axis_tready, q_count == CW'(FIFO_DEPTH), "input stalled with room")

endmodule

[bench/tb_integer_divide_remainder_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_divide_remainder_unit
// Streams divide / remainder operations into the unit with random gaps and
// output stalls, computes each expected result locally and checks every
// result beat in order against it.
// ----------------------------------------------------------------------------
module tb_integer_divide_remainder_unit;
	import idru_pkg::*;

	localparam int N_RANDOM   = 1250;
	localparam int STALL_MAX  = 20000;
	localparam logic [63:0] I64_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ALL_ONES = '1;
	localparam logic [63:0] I32_MIN = 64'h0000_0000_8000_0000;
	localparam logic [63:0] U32_MAX = 64'h0000_0000_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        word_op;
		logic [63:0] dividend;
		logic [63:0] divisor;
	} div_op_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;   // dividend[63:0], divisor[127:64]
	logic [2:0]   s_axis_tuser;   // cmd[1:0], word_op[2]
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;   // result[63:0]

	div_op_t     pending_ops[$];
	logic [63:0] expected_results[$];
	int          n_errors;
	int          n_sent;
	int          n_checked;
	int          idle_cycles;
	int          cyc;
	bit          stim_done;

	integer_divide_remainder_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] sx32(logic [63:0] v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

	// expected quotient / remainder under the RV64M rules
	function automatic logic [63:0] divrem_result(div_op_t op);
		logic [63:0] a, b, ma, mb, q, r, res;
		logic        sgn, rem, na, nb;
		sgn = (op.cmd == CMD_DIV) || (op.cmd == CMD_REM);
		rem = (op.cmd == CMD_REM) || (op.cmd == CMD_REMU);
		a = op.dividend;
		b = op.divisor;
		if (op.word_op) begin
			a = sgn ? sx32(a) : (a & U32_MAX);
			b = sgn ? sx32(b) : (b & U32_MAX);
		end
		na = sgn & a[63];
		nb = sgn & b[63];
		if (b == 0) begin
			res = rem ? a : ALL_ONES;
		end else begin
			ma = na ? -a : a;
			mb = nb ? -b : b;
			q = ma / mb;
			r = ma % mb;
			if (rem) res = na ? -r : r;
			else res = (na != nb) ? -q : q;
		end
		return op.word_op ? sx32(res) : res;
	endfunction

	function automatic logic [63:0] rand64();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = ALL_ONES;
			2: v = I64_MIN;
			3: v = I32_MIN;
			4: v = v >> $urandom_range(1, 63);
			5: v = ALL_ONES - (v >> $urandom_range(40, 63));
			6: v = $urandom_range(0, 15);
			default: ;
		endcase
		return v;
	endfunction

	task automatic report_mismatch(logic [63:0] got, logic [63:0] want);
		$display("mismatch on result %0d: got %h, expected %h", n_checked, got, want);
		n_errors++;
	endtask

	task automatic queue_op(logic [1:0] c, logic w, logic [63:0] a, logic [63:0] b);
		div_op_t op;
		op.cmd = c;
		op.word_op = w;
		op.dividend = a;
		op.divisor = b;
		pending_ops.push_back(op);
	endtask

	// stimulus: directed corners, then random operations
	initial begin
		logic [1:0] c;
		n_errors = 0;
		stim_done = 0;
		for (int w = 0; w < 2; w++) begin
			for (int k = 0; k < 4; k++) begin
				c = k[1:0];
				queue_op(c, w[0], 64'd12345, 64'd0);        // divide by zero
				queue_op(c, w[0], w ? I32_MIN : I64_MIN, ALL_ONES); // overflow
			end
			queue_op(CMD_DIV, w[0], -64'sd7, 64'd2);
			queue_op(CMD_REM, w[0], -64'sd7, 64'd2);
			queue_op(CMD_DIVU, w[0], ALL_ONES, 64'd1);
			queue_op(CMD_REMU, w[0], ALL_ONES, ALL_ONES);
		end
		for (int i = 0; i < N_RANDOM; i++)
			queue_op($urandom_range(0, 3), $urandom_range(0, 1), rand64(), rand64());
		stim_done = 1;
	end

	// idling: with a probability of 31 percent, none during a stretch in the middle
	function automatic bit take_gap();
		if (cyc > 600 && cyc < 1100) return 0;
		return $urandom_range(0, 99) < 31;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
			m_axis_tready <= 1'b0;
			n_sent <= 0;
		end else begin
			m_axis_tready <= !take_gap();
			if (!s_axis_tvalid || s_axis_tready) begin
				if (s_axis_tvalid) n_sent <= n_sent + 1;
				if (pending_ops.size() > 0 && !take_gap()) begin
					div_op_t op;
					op = pending_ops.pop_front();
					expected_results.push_back(divrem_result(op));
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {op.divisor, op.dividend};
					s_axis_tuser  <= {op.word_op, op.cmd};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and stall watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_checked <= 0;
			idle_cycles <= 0;
			cyc <= 0;
		end else begin
			cyc <= cyc + 1;
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$display("unexpected result beat %h", m_axis_tdata);
					n_errors++;
				end else begin
					logic [63:0] want;
					want = expected_results.pop_front();
					if (m_axis_tdata !== want) report_mismatch(m_axis_tdata, want);
				end
				n_checked <= n_checked + 1;
			end
		end
	end

	// reset, end of run, timeout
	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		fork
			begin
				wait (stim_done && pending_ops.size() == 0 && !s_axis_tvalid
					&& expected_results.size() == 0);
				repeat (100) @(posedge clk);
			end
			begin
				wait (idle_cycles >= STALL_MAX);
			end
		join_any
		$display("ran %0d operations, checked %0d results (div/rem, signed/unsigned, word/full)",
			n_sent, n_checked);
		if (idle_cycles < STALL_MAX && n_errors == 0 && expected_results.size() == 0)
			$display("integer_divide_remainder_unit verification clean");
		else
			$display("integer_divide_remainder_unit verification failed");
		$finish;
	end

endmodule
